// ----- src/lrk_pkg.sv -----
package lrk_pkg;

   localparam int DataWidth = 48;
   localparam int StepWidth = 33;

   typedef logic signed [DataWidth-1:0] data_type;

   localparam data_type MaxVal = 48'sh7FFF_FFFF_FFFF;
   localparam data_type MinVal = 48'sh8000_0000_0000;

   localparam data_type ConstBeta  = 48'sd11453246123;
   localparam data_type ConstHalf  = 48'sd2147483648;
   localparam data_type ConstSixth = 48'sd715827883;

   localparam data_type ResetInitX = 48'sd0;
   localparam data_type ResetInitY = 48'sd4294967296;
   localparam data_type ResetInitZ = 48'sd4294967296;
   localparam logic [StepWidth-1:0] ResetStepH = 33'd4294967;
   localparam data_type ResetStartTime = 48'sd0;

   localparam logic [2:0] RegInitX     = 3'd0;
   localparam logic [2:0] RegInitY     = 3'd1;
   localparam logic [2:0] RegInitZ     = 3'd2;
   localparam logic [2:0] RegStepH     = 3'd3;
   localparam logic [2:0] RegStartTime = 3'd4;

   localparam logic [2:0] OpAdd   = 3'd0;
   localparam logic [2:0] OpSub   = 3'd1;
   localparam logic [2:0] OpMul10 = 3'd2;
   localparam logic [2:0] OpMul28 = 3'd3;
   localparam logic [2:0] OpFmul  = 3'd4;
   localparam logic [2:0] OpNop   = 3'd5;
   localparam logic [2:0] OpEnd   = 3'd6;

   localparam logic [5:0] AddrA     = 6'd0;
   localparam logic [5:0] AddrB     = 6'd1;
   localparam logic [5:0] AddrC     = 6'd2;
   localparam logic [5:0] AddrD     = 6'd3;
   localparam logic [5:0] AddrS     = 6'd4;
   localparam logic [5:0] AddrP     = 6'd5;
   localparam logic [5:0] AddrT0    = 6'd6;
   localparam logic [5:0] AddrK1    = 6'd9;
   localparam logic [5:0] AddrK2    = 6'd12;
   localparam logic [5:0] AddrK3    = 6'd15;
   localparam logic [5:0] AddrK4    = 6'd18;
   localparam logic [5:0] AddrSx    = 6'd32;
   localparam logic [5:0] AddrSy    = 6'd33;
   localparam logic [5:0] AddrSz    = 6'd34;
   localparam logic [5:0] AddrTime  = 6'd35;
   localparam logic [5:0] AddrH     = 6'd36;
   localparam logic [5:0] AddrBeta  = 6'd37;
   localparam logic [5:0] AddrHalf  = 6'd38;
   localparam logic [5:0] AddrSixth = 6'd39;

   localparam int MemDepth = 21;

   typedef struct packed {
      logic [2:0] op;
      logic [5:0] dst;
      logic [5:0] src_a;
      logic [5:0] src_b;
   } uop_type;

   typedef struct packed {
      logic    load;
      logic    restart;
      logic    ex;
      logic    wr_en;
      uop_type uop;
   } ctrl_type;

   typedef struct packed {
      data_type                init_x;
      data_type                init_y;
      data_type                init_z;
      logic [StepWidth-1:0]    step_h;
      data_type                start_time;
   } cfg_type;

   typedef struct packed {
      data_type time_now;
      data_type pos_x;
      data_type pos_y;
      data_type pos_z;
   } snap_type;

   function automatic uop_type mk(logic [2:0] op, logic [5:0] dst, logic [5:0] a,
                                  logic [5:0] b);
      uop_type u;
      u.op    = op;
      u.dst   = dst;
      u.src_a = a;
      u.src_b = b;
      return u;
   endfunction

   function automatic uop_type deriv_op(logic [6:0] idx, logic [5:0] rx, logic [5:0] ry,
                                        logic [5:0] rz, logic [5:0] kb);
      uop_type u;
      unique case (idx)
         7'd0:    u = mk(OpSub, AddrA, ry, rx);
         7'd1:    u = mk(OpMul10, AddrA, AddrA, AddrA);
         7'd2:    u = mk(OpMul28, AddrB, rx, rx);
         7'd3:    u = mk(OpFmul, AddrC, rx, rz);
         7'd4:    u = mk(OpSub, AddrB, AddrB, AddrC);
         7'd5:    u = mk(OpSub, AddrB, AddrB, ry);
         7'd6:    u = mk(OpFmul, AddrC, rx, ry);
         7'd7:    u = mk(OpFmul, AddrD, AddrBeta, rz);
         7'd8:    u = mk(OpSub, AddrC, AddrC, AddrD);
         7'd9:    u = mk(OpFmul, kb, AddrH, AddrA);
         7'd10:   u = mk(OpFmul, 6'(kb + 6'd1), AddrH, AddrB);
         7'd11:   u = mk(OpFmul, 6'(kb + 6'd2), AddrH, AddrC);
         default: u = mk(OpNop, AddrA, AddrA, AddrA);
      endcase
      return u;
   endfunction

   function automatic uop_type half_op(logic [6:0] idx, logic [5:0] kb);
      logic [5:0] i;
      uop_type    u;
      i = {4'd0, idx[2:1]};
      if (idx[0] == 1'b0) begin
         u = mk(OpFmul, AddrP, AddrHalf, 6'(kb + i));
      end else begin
         u = mk(OpAdd, 6'(AddrT0 + i), 6'(AddrSx + i), AddrP);
      end
      return u;
   endfunction

   function automatic uop_type final_op(logic [6:0] idx);
      logic [5:0] i;
      uop_type    u;
      i = {4'd0, idx[4:3]};
      unique case (idx[2:0])
         3'd0:    u = mk(OpAdd, AddrS, 6'(AddrK1 + i), 6'(AddrK2 + i));
         3'd1:    u = mk(OpAdd, AddrS, AddrS, 6'(AddrK2 + i));
         3'd2:    u = mk(OpAdd, AddrS, AddrS, 6'(AddrK3 + i));
         3'd3:    u = mk(OpAdd, AddrS, AddrS, 6'(AddrK3 + i));
         3'd4:    u = mk(OpAdd, AddrS, AddrS, 6'(AddrK4 + i));
         3'd5:    u = mk(OpFmul, AddrS, AddrSixth, AddrS);
         3'd6:    u = mk(OpAdd, 6'(AddrSx + i), 6'(AddrSx + i), AddrS);
         default: u = mk(OpNop, AddrA, AddrA, AddrA);
      endcase
      return u;
   endfunction

   function automatic uop_type prog_op(logic [6:0] pc);
      uop_type u;
      if (pc < 7'd12) begin
         u = deriv_op(pc, AddrSx, AddrSy, AddrSz, AddrK1);
      end else if (pc < 7'd18) begin
         u = half_op(7'(pc - 7'd12), AddrK1);
      end else if (pc < 7'd30) begin
         u = deriv_op(7'(pc - 7'd18), AddrT0, 6'(AddrT0 + 6'd1), 6'(AddrT0 + 6'd2), AddrK2);
      end else if (pc < 7'd36) begin
         u = half_op(7'(pc - 7'd30), AddrK2);
      end else if (pc < 7'd48) begin
         u = deriv_op(7'(pc - 7'd36), AddrT0, 6'(AddrT0 + 6'd1), 6'(AddrT0 + 6'd2), AddrK3);
      end else if (pc < 7'd51) begin
         u = mk(OpAdd, 6'(AddrT0 + 6'(pc - 7'd48)), 6'(AddrSx + 6'(pc - 7'd48)),
                6'(AddrK3 + 6'(pc - 7'd48)));
      end else if (pc < 7'd63) begin
         u = deriv_op(7'(pc - 7'd51), AddrT0, 6'(AddrT0 + 6'd1), 6'(AddrT0 + 6'd2), AddrK4);
      end else if (pc < 7'd87) begin
         u = final_op(7'(pc - 7'd63));
      end else if (pc == 7'd87) begin
         u = mk(OpAdd, AddrTime, AddrTime, AddrH);
      end else begin
         u = mk(OpEnd, AddrA, AddrA, AddrA);
      end
      return u;
   endfunction

endpackage

// ----- src/lrk_fmul.sv -----
module lrk_fmul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  lrk_pkg::data_type  op_a,
   input  lrk_pkg::data_type  op_b,
   output logic               done,
   output lrk_pkg::data_type  result,
   output logic               sat
);

   logic        busy_ff, busy_in;
   logic [2:0]  step_ff, step_in;
   logic [47:0] ma_ff, ma_in, mb_ff, mb_in;
   logic        neg_ff, neg_in;
   logic [63:0] prod_ff, prod_in;
   logic [95:0] acc_ff, acc_in;
   logic [31:0] mx, my;
   logic [95:0] addend;
   logic [80:0] rnd;
   logic [48:0] mag;

   assign mx = step_ff[0] ? {16'd0, ma_ff[47:32]} : ma_ff[31:0];
   assign my = step_ff[1] ? {16'd0, mb_ff[47:32]} : mb_ff[31:0];

   always_comb begin
      unique case (step_ff)
         3'd1:    addend = {32'd0, prod_ff};
         3'd2:    addend = {prod_ff, 32'd0};
         3'd3:    addend = {prod_ff, 32'd0};
         3'd4:    addend = {prod_ff[31:0], 64'd0};
         default: addend = 96'd0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      neg_in  = neg_ff;
      prod_in = mx * my;
      acc_in  = acc_ff + addend;
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
         ma_in   = op_a[47] ? 48'(~op_a + 48'sd1) : op_a;
         mb_in   = op_b[47] ? 48'(~op_b + 48'sd1) : op_b;
         neg_in  = op_a[47] ^ op_b[47];
         acc_in  = 96'd0;
      end else if (busy_ff) begin
         step_in = 3'(step_ff + 3'd1);
         if (step_ff == 3'd5) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign rnd  = {1'b0, acc_ff[79:0]} + 81'h8000_0000;
   assign mag  = rnd[80:32];
   assign done = busy_ff && (step_ff == 3'd5);

   always_comb begin
      sat    = 1'b0;
      result = neg_ff ? 48'(-mag[47:0]) : mag[47:0];
      if (acc_ff[95:80] != 16'd0) begin
         sat    = 1'b1;
         result = neg_ff ? lrk_pkg::MinVal : lrk_pkg::MaxVal;
      end else if (!neg_ff && mag > 49'(lrk_pkg::MaxVal)) begin
         sat    = 1'b1;
         result = lrk_pkg::MaxVal;
      end else if (neg_ff && mag > 49'h0_8000_0000_0000) begin
         sat    = 1'b1;
         result = lrk_pkg::MinVal;
      end
   end

endmodule

// ----- src/lrk_datapath.sv -----
module lrk_datapath (
   input  logic               clock,
   input  logic               reset,
   input  lrk_pkg::ctrl_type  ctrl,
   input  lrk_pkg::cfg_type   cfg,
   output logic               mul_done,
   output lrk_pkg::snap_type  snap,
   output logic               overflow
);

   lrk_pkg::data_type mem_ff [lrk_pkg::MemDepth];
   lrk_pkg::data_type rd_a_ff, rd_b_ff;
   lrk_pkg::data_type x_ff, y_ff, z_ff, t_ff;
   lrk_pkg::snap_type snap_ff;
   logic              ovf_ff;
   lrk_pkg::data_type opnd_a, opnd_b, alu_res, mul_res, wr_data;
   logic signed [53:0] wa, wb, wide;
   logic              alu_sat, mul_sat, wr_sat;

   function automatic lrk_pkg::data_type pick(logic [5:0] addr, lrk_pkg::data_type mem_val,
                                              lrk_pkg::data_type x, lrk_pkg::data_type y,
                                              lrk_pkg::data_type z, lrk_pkg::data_type t,
                                              logic [32:0] h);
      lrk_pkg::data_type v;
      if (!addr[5]) begin
         v = mem_val;
      end else begin
         unique case (addr[2:0])
            3'd0:    v = x;
            3'd1:    v = y;
            3'd2:    v = z;
            3'd3:    v = t;
            3'd4:    v = {15'd0, h};
            3'd5:    v = lrk_pkg::ConstBeta;
            3'd6:    v = lrk_pkg::ConstHalf;
            default: v = lrk_pkg::ConstSixth;
         endcase
      end
      return v;
   endfunction

   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[ctrl.uop.src_a[4:0]];
      rd_b_ff <= mem_ff[ctrl.uop.src_b[4:0]];
      if (ctrl.wr_en && !ctrl.uop.dst[5]) begin
         mem_ff[ctrl.uop.dst[4:0]] <= wr_data;
      end
   end

   assign opnd_a = pick(ctrl.uop.src_a, rd_a_ff, x_ff, y_ff, z_ff, t_ff, cfg.step_h);
   assign opnd_b = pick(ctrl.uop.src_b, rd_b_ff, x_ff, y_ff, z_ff, t_ff, cfg.step_h);

   assign wa = 54'(opnd_a);
   assign wb = 54'(opnd_b);

   always_comb begin
      unique case (ctrl.uop.op)
         lrk_pkg::OpSub:   wide = wa - wb;
         lrk_pkg::OpMul10: wide = (wa <<< 3) + (wa <<< 1);
         lrk_pkg::OpMul28: wide = (wa <<< 5) - (wa <<< 2);
         default:          wide = wa + wb;
      endcase
      alu_sat = 1'b1;
      if (wide > 54'(lrk_pkg::MaxVal)) begin
         alu_res = lrk_pkg::MaxVal;
      end else if (wide < 54'(lrk_pkg::MinVal)) begin
         alu_res = lrk_pkg::MinVal;
      end else begin
         alu_res = wide[47:0];
         alu_sat = 1'b0;
      end
   end

   lrk_fmul u_fmul (
      .clock  (clock),
      .reset  (reset),
      .start  (ctrl.ex && (ctrl.uop.op == lrk_pkg::OpFmul)),
      .op_a   (opnd_a),
      .op_b   (opnd_b),
      .done   (mul_done),
      .result (mul_res),
      .sat    (mul_sat)
   );

   assign wr_data = (ctrl.uop.op == lrk_pkg::OpFmul) ? mul_res : alu_res;
   assign wr_sat  = (ctrl.uop.op == lrk_pkg::OpFmul) ? mul_sat : alu_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= lrk_pkg::ResetInitX;
         y_ff   <= lrk_pkg::ResetInitY;
         z_ff   <= lrk_pkg::ResetInitZ;
         t_ff   <= '0;
         ovf_ff <= 1'b0;
      end else if (ctrl.load) begin
         ovf_ff <= 1'b0;
         if (ctrl.restart) begin
            x_ff <= cfg.init_x;
            y_ff <= cfg.init_y;
            z_ff <= cfg.init_z;
            t_ff <= cfg.start_time;
         end
      end else if (ctrl.wr_en) begin
         if (wr_sat) begin
            ovf_ff <= 1'b1;
         end
         if (ctrl.uop.dst[5]) begin
            unique case (ctrl.uop.dst[1:0])
               2'd0:    x_ff <= wr_data;
               2'd1:    y_ff <= wr_data;
               2'd2:    z_ff <= wr_data;
               default: t_ff <= wr_data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         if (ctrl.restart) begin
            snap_ff <= '{cfg.start_time, cfg.init_x, cfg.init_y, cfg.init_z};
         end else begin
            snap_ff <= '{t_ff, x_ff, y_ff, z_ff};
         end
      end
   end

   assign snap     = snap_ff;
   assign overflow = ovf_ff;

endmodule

// ----- src/lorenz_rk4_integrator_unit.sv -----
// Lorenz integrator: every request transfer returns one response holding the time and
// the (x, y, z) state as they stand before the step, then advances the state by one
// fourth-order Runge-Kutta step of size step_h in signed Q16.32 with saturation. A sequencer
// runs an 88-entry micro-op program over one saturating adder and one fixed-point
// multiplier, and each of the 33 products needs four passes through a single 32x32
// multiplier. The next request is taken while the previous response still waits.
module lorenz_rk4_integrator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [47:0] rsp_time_out,
   output logic [47:0] rsp_x_out,
   output logic [47:0] rsp_y_out,
   output logic [47:0] rsp_z_out,
   output logic        rsp_overflow,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_write_data
);

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StRead = 3'd1;
   localparam logic [2:0] StExec = 3'd2;
   localparam logic [2:0] StMul  = 3'd3;
   localparam logic [2:0] StDone = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [6:0]        pc_ff, pc_in;
   lrk_pkg::cfg_type  cfg_ff;
   lrk_pkg::ctrl_type ctrl;
   lrk_pkg::snap_type snap;
   logic              mul_done, overflow;
   logic              rsp_valid_ff, rsp_valid_in;
   lrk_pkg::snap_type rsp_ff;
   logic              rsp_ovf_ff;
   logic              rsp_load;
   logic              wr_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_x     <= lrk_pkg::ResetInitX;
         cfg_ff.init_y     <= lrk_pkg::ResetInitY;
         cfg_ff.init_z     <= lrk_pkg::ResetInitZ;
         cfg_ff.step_h     <= lrk_pkg::ResetStepH;
         cfg_ff.start_time <= lrk_pkg::ResetStartTime;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lrk_pkg::RegInitX:     cfg_ff.init_x     <= csr_write_data;
            lrk_pkg::RegInitY:     cfg_ff.init_y     <= csr_write_data;
            lrk_pkg::RegInitZ:     cfg_ff.init_z     <= csr_write_data;
            lrk_pkg::RegStepH:     cfg_ff.step_h     <= csr_write_data[32:0];
            lrk_pkg::RegStartTime: cfg_ff.start_time <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_ready    = (state_ff == StIdle);
   assign ctrl.uop     = lrk_pkg::prog_op(pc_ff);
   assign ctrl.load    = req_valid && req_ready;
   assign ctrl.restart = req_restart;
   assign ctrl.ex      = (state_ff == StExec);
   assign ctrl.wr_en   = wr_en;
   assign rsp_load     = (state_ff == StDone) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      wr_en    = 1'b0;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               pc_in    = 7'd0;
               state_in = StRead;
            end
         end
         StRead: begin
            if (ctrl.uop.op == lrk_pkg::OpEnd) begin
               state_in = StDone;
            end else if (ctrl.uop.op == lrk_pkg::OpNop) begin
               pc_in = 7'(pc_ff + 7'd1);
            end else begin
               state_in = StExec;
            end
         end
         StExec: begin
            if (ctrl.uop.op == lrk_pkg::OpFmul) begin
               state_in = StMul;
            end else begin
               wr_en    = 1'b1;
               pc_in    = 7'(pc_ff + 7'd1);
               state_in = StRead;
            end
         end
         StMul: begin
            if (mul_done) begin
               wr_en    = 1'b1;
               pc_in    = 7'(pc_ff + 7'd1);
               state_in = StRead;
            end
         end
         StDone: begin
            if (rsp_load) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         pc_ff        <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_ff     <= snap;
         rsp_ovf_ff <= overflow;
      end
   end

   lrk_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .cfg      (cfg_ff),
      .mul_done (mul_done),
      .snap     (snap),
      .overflow (overflow)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_time_out = rsp_ff.time_now;
   assign rsp_x_out    = rsp_ff.pos_x;
   assign rsp_y_out    = rsp_ff.pos_y;
   assign rsp_z_out    = rsp_ff.pos_z;
   assign rsp_overflow = rsp_ovf_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == StRead))
      else $error("request transfer did not start the program");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StIdle || state_ff == StDone) |-> !ctrl.wr_en)
      else $error("datapath write outside the program");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == StDone))
      else $error("response raised without a finished step");

endmodule

// ----- tb/lorenz_rk4_integrator_unit_checker.sv -----
`timescale 1ns / 100ps

module lorenz_rk4_integrator_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_restart,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [47:0] rsp_time_out,
   input  logic [47:0] rsp_x_out,
   input  logic [47:0] rsp_y_out,
   input  logic [47:0] rsp_z_out,
   input  logic        rsp_overflow,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_write_data,
   output int          fail_count,
   output int          pending_count,
   output int          overflow_seen
);

   typedef struct {
      logic [47:0] t;
      logic [47:0] x;
      logic [47:0] y;
      logic [47:0] z;
      logic        ovf;
   } state_report_type;

   state_report_type expected_reports[$];

   longint cfg_x, cfg_y, cfg_z, cfg_t;
   longint cfg_h;
   longint cur_x, cur_y, cur_z, cur_t;
   bit     saturated;

   localparam longint MaxQ = 64'sh7FFF_FFFF_FFFF;
   localparam longint MinQ = -64'sh8000_0000_0000;

   function automatic longint sx48(logic [47:0] v);
      return longint'($signed(v));
   endfunction

   function automatic longint clamp48(longint v);
      if (v > MaxQ) begin
         saturated = 1'b1;
         return MaxQ;
      end
      if (v < MinQ) begin
         saturated = 1'b1;
         return MinQ;
      end
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      logic signed [127:0] p;
      logic [127:0]        m;
      logic [127:0]        r;
      bit                  neg;
      p = 128'(a) * 128'(b);
      neg = p < 0;
      m = neg ? 128'(-p) : 128'(p);
      r = (m + 128'h8000_0000) >> 32;
      if (!neg && r > 128'(MaxQ)) begin
         saturated = 1'b1;
         return MaxQ;
      end
      if (neg && r > 128'h8000_0000_0000) begin
         saturated = 1'b1;
         return MinQ;
      end
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic void lorenz_slope(input longint px, py, pz, h,
                                        output longint kx, ky, kz);
      longint fx, fy, fz;
      fx = clamp48(10 * clamp48(py - px));
      fy = clamp48(clamp48(clamp48(28 * px) - qmul(px, pz)) - py);
      fz = clamp48(qmul(px, py) - qmul(sx48(lrk_pkg::ConstBeta), pz));
      kx = qmul(h, fx);
      ky = qmul(h, fy);
      kz = qmul(h, fz);
   endfunction

   function automatic longint blend(longint r, longint a, longint b, longint c, longint d);
      longint s;
      s = clamp48(a + b);
      s = clamp48(s + b);
      s = clamp48(s + c);
      s = clamp48(s + c);
      s = clamp48(s + d);
      return clamp48(r + qmul(sx48(lrk_pkg::ConstSixth), s));
   endfunction

   function automatic void advance_state(bit restart);
      longint a1, b1, c1, a2, b2, c2, a3, b3, c3, a4, b4, c4;
      longint hf;
      state_report_type e;
      if (restart) begin
         cur_x = cfg_x;
         cur_y = cfg_y;
         cur_z = cfg_z;
         cur_t = cfg_t;
      end
      e.t = cur_t[47:0];
      e.x = cur_x[47:0];
      e.y = cur_y[47:0];
      e.z = cur_z[47:0];
      saturated = 1'b0;
      hf = sx48(lrk_pkg::ConstHalf);
      lorenz_slope(cur_x, cur_y, cur_z, cfg_h, a1, b1, c1);
      lorenz_slope(clamp48(cur_x + qmul(hf, a1)), clamp48(cur_y + qmul(hf, b1)),
                   clamp48(cur_z + qmul(hf, c1)), cfg_h, a2, b2, c2);
      lorenz_slope(clamp48(cur_x + qmul(hf, a2)), clamp48(cur_y + qmul(hf, b2)),
                   clamp48(cur_z + qmul(hf, c2)), cfg_h, a3, b3, c3);
      lorenz_slope(clamp48(cur_x + a3), clamp48(cur_y + b3), clamp48(cur_z + c3),
                   cfg_h, a4, b4, c4);
      cur_x = blend(cur_x, a1, a2, a3, a4);
      cur_y = blend(cur_y, b1, b2, b3, b4);
      cur_z = blend(cur_z, c1, c2, c3, c4);
      cur_t = clamp48(cur_t + cfg_h);
      e.ovf = saturated;
      expected_reports.push_back(e);
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   assign pending_count = expected_reports.size();

   always @(posedge clock) begin
      state_report_type e;
      if (reset) begin
         cfg_x = sx48(lrk_pkg::ResetInitX);
         cfg_y = sx48(lrk_pkg::ResetInitY);
         cfg_z = sx48(lrk_pkg::ResetInitZ);
         cfg_h = longint'(lrk_pkg::ResetStepH);
         cfg_t = sx48(lrk_pkg::ResetStartTime);
         cur_x = cfg_x;
         cur_y = cfg_y;
         cur_z = cfg_z;
         cur_t = 0;
         expected_reports.delete();
         fail_count = 0;
         overflow_seen = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               lrk_pkg::RegInitX:     cfg_x = sx48(csr_write_data);
               lrk_pkg::RegInitY:     cfg_y = sx48(csr_write_data);
               lrk_pkg::RegInitZ:     cfg_z = sx48(csr_write_data);
               lrk_pkg::RegStepH:     cfg_h = longint'(csr_write_data[32:0]);
               lrk_pkg::RegStartTime: cfg_t = sx48(csr_write_data);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_x_out, '0);
            end else begin
               e = expected_reports.pop_front();
               if (rsp_time_out !== e.t) report_mismatch("time_out", rsp_time_out, e.t);
               if (rsp_x_out !== e.x) report_mismatch("x_out", rsp_x_out, e.x);
               if (rsp_y_out !== e.y) report_mismatch("y_out", rsp_y_out, e.y);
               if (rsp_z_out !== e.z) report_mismatch("z_out", rsp_z_out, e.z);
               if (rsp_overflow !== e.ovf) begin
                  report_mismatch("overflow", 48'(rsp_overflow), 48'(e.ovf));
               end
               if (e.ovf) overflow_seen++;
            end
         end
         if (req_valid && req_ready) advance_state(req_restart);
      end
   end

endmodule

// ----- tb/lorenz_rk4_integrator_unit_test.sv -----
`timescale 1ns / 100ps

module lorenz_rk4_integrator_unit_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [47:0] rsp_time_out, rsp_x_out, rsp_y_out, rsp_z_out;
   logic        rsp_overflow;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [47:0] csr_write_data = '0;
   int          fail_count, pending_count, overflow_seen;
   int          idle_cycles = 0;
   int          steps_sent = 0;
   bit          calm = 1'b0;

   localparam int IdleLimit = 20000;
   localparam logic [2:0] RegUnusedLow  = 3'd5;
   localparam logic [2:0] RegUnusedHigh = 3'd7;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lorenz_rk4_integrator_unit dut (.*);

   lorenz_rk4_integrator_unit_checker checker_i (.*);

   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("watchdog expired with %0d results pending", pending_count);
         $display("lorenz_rk4_integrator_unit_test failed");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [47:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic send_step(bit restart);
      if (!calm && $urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_valid <= 1'b0;
      steps_sent++;
      @(posedge clock);
   endtask

   task automatic load_settings(logic [47:0] x, logic [47:0] y, logic [47:0] z,
                                logic [32:0] h, logic [47:0] t0);
      drain();
      write_reg(lrk_pkg::RegInitX, x);
      write_reg(lrk_pkg::RegInitY, y);
      write_reg(lrk_pkg::RegInitZ, z);
      write_reg(lrk_pkg::RegStepH, 48'(h));
      write_reg(lrk_pkg::RegStartTime, t0);
   endtask

   function automatic logic [47:0] small_value();
      return 48'($signed(32'($urandom_range(0, 40 << 16)) - 32'(20 << 16))) << 16;
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_step(1'b0);
      send_step(1'b0);
      send_step(1'b1);
      load_settings(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
                    33'h1_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
      send_step(1'b1);
      send_step(1'b0);
      load_settings(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
                    33'd0, 48'h8000_0000_0000);
      send_step(1'b1);
      send_step(1'b0);
      load_settings('0, '0, '0, 33'd1, 48'hFFFF_FFFF_FFFF);
      send_step(1'b1);
      send_step(1'b0);
      drain();
      write_reg(RegUnusedLow, 48'h1234_5678_9ABC);
      write_reg(RegUnusedHigh, 48'hFFFF_FFFF_FFFF);
      load_settings(48'h1_0000_0000, 48'h1_0000_0000, 48'h1_0000_0000,
                    33'h1_0000_0000, 48'h7FFF_0000_0000);
      send_step(1'b1);
      repeat (4) send_step(1'b0);
      load_settings(48'h5555_AAAA_5555, 48'hAAAA_5555_AAAA, 48'h0000_FFFF_0000,
                    33'h1_5555_5555, 48'h5555_AAAA_5555);
      send_step(1'b1);
      send_step(1'b0);

      for (int phase = 0; phase < 10; phase++) begin
         if (phase >= 8) calm = 1'b1;
         case (phase % 4)
            0: load_settings(small_value(), small_value(), small_value(),
                             33'($urandom_range(1, 1 << 26)), small_value());
            1: load_settings(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                             48'({$urandom, $urandom}), 33'({$urandom, $urandom}),
                             48'({$urandom, $urandom}));
            2: load_settings(small_value(), small_value(), small_value(),
                             {1'b0, $urandom}, 48'({$urandom, $urandom}));
            default: load_settings(48'h0, 48'h1_0000_0000, 48'h1_0000_0000,
                                   33'd4294967, small_value());
         endcase
         send_step(1'b1);
         for (int n = 0; n < 95; n++) send_step($urandom_range(0, 15) == 0);
         if (phase == 3) begin
            while (pending_count != 0) @(posedge clock);
         end
      end

      drain();
      $display("sent %0d steps over 15 register settings, %0d results saturated",
               steps_sent, overflow_seen);
      if (fail_count == 0) begin
         $display("lorenz_rk4_integrator_unit_test passed");
      end else begin
         $display("lorenz_rk4_integrator_unit_test failed");
      end
      $finish;
   end

endmodule
